/* rtl/linked_list_delete_manager_unit_defines.svh */
// Assertion macros shared by the list manager RTL.
`ifndef LINKED_LIST_DELETE_MANAGER_UNIT_DEFINES_SVH
`define LINKED_LIST_DELETE_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LLDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LLDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lldm_pkg.sv */
package lldm_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LEN_W    = 9;
   localparam int DATA_W   = 32;

   typedef enum logic [2:0] {
      CMD_APPEND     = 3'd0,
      CMD_SEARCH     = 3'd1,
      CMD_DEL_FIRST  = 3'd2,
      CMD_DEL_LAST   = 3'd3,
      CMD_DEL_VALUE  = 3'd4,
      CMD_DEL_BEFORE = 3'd5,
      CMD_DEL_AFTER  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK          = 3'd0,
      STS_EMPTY       = 3'd1,
      STS_NOT_FOUND   = 3'd2,
      STS_NO_NEIGHBOR = 3'd3,
      STS_FULL        = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APP_NODE,
      ST_APP_LINK,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_UNL_RD,
      ST_UNL_DAT,
      ST_RESP
   } state_type;

endpackage

/* rtl/linked_list_delete_manager_unit.sv */
// Linked list manager: a circular doubly linked list of signed 32-bit values
// in a 256-slot store.
// Request channel (req_valid/req_stall): req_command and req_value form one
// transaction; req_stall stays high while a command is in progress.
// Response channel (rsp_valid/rsp_stall): one transaction per command with
// status, position, new length and removed value, held in an output register.
// Steps: append scans for the lowest free slot (free-slot scan, one slot a
// cycle), writes the node and, unless the list was empty, links it. Delete
// first/last read the entry, then unlink it. Value commands walk the list, a read
// and a compare per visited entry (one store read port), then do the unlink.
// A new request is taken the cycle after the response is loaded, even while
// the previous response still waits under rsp_stall.
// Reset empties the list at once; no clearing pass is needed.
// While rsp_stall is high the response holds and a finished command waits.
module linked_list_delete_manager_unit
   import lldm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_command,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [LEN_W-1:0]         rsp_position,
   output logic [LEN_W-1:0]         rsp_length,
   output logic signed [DATA_W-1:0] rsp_removed_value
);

`include "linked_list_delete_manager_unit_defines.svh"

   logic [DATA_W-1:0] val_mem [CAPACITY];
   logic [IDX_W-1:0]  nxt_mem [CAPACITY];
   logic [IDX_W-1:0]  prv_mem [CAPACITY];

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CAPACITY-1:0] in_use_ff, in_use_in;
   logic [IDX_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   status_type        res_sts_ff, res_sts_in;
   logic [CNT_W-1:0]  res_pos_ff, res_pos_in;
   logic [DATA_W-1:0] res_rem_ff, res_rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_position_ff, rsp_position_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [DATA_W-1:0] rsp_removed_ff, rsp_removed_in;

   logic [DATA_W-1:0] val_rd_ff;
   logic [IDX_W-1:0]  nxt_rd_ff, prv_rd_ff;

   logic              val_we, nxt_we, prv_we;
   logic [IDX_W-1:0]  val_wa, nxt_wa, prv_wa;
   logic [DATA_W-1:0] val_wd;
   logic [IDX_W-1:0]  nxt_wd, prv_wd;
   logic              req_take, out_free;

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
      end
      if (nxt_we) begin
         nxt_mem[nxt_wa] <= nxt_wd;
      end
      if (prv_we) begin
         prv_mem[prv_wa] <= prv_wd;
      end
      val_rd_ff <= val_mem[addr_ff];
      nxt_rd_ff <= nxt_mem[addr_ff];
      prv_rd_ff <= prv_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      pos_ff          <= pos_in;
      addr_ff         <= addr_in;
      scan_ff         <= scan_in;
      res_sts_ff      <= res_sts_in;
      res_pos_ff      <= res_pos_in;
      res_rem_ff      <= res_rem_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_removed_ff  <= rsp_removed_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      in_use_in       = in_use_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      addr_in         = addr_ff;
      scan_in         = scan_ff;
      res_sts_in      = res_sts_ff;
      res_pos_in      = res_pos_ff;
      res_rem_in      = res_rem_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_removed_in  = rsp_removed_ff;
      val_we          = 1'b0;
      val_wa          = scan_ff;
      val_wd          = key_ff;
      nxt_we          = 1'b0;
      nxt_wa          = scan_ff;
      nxt_wd          = scan_ff;
      prv_we          = 1'b0;
      prv_wa          = scan_ff;
      prv_wd          = scan_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in     = cmd_type'(req_command);
               key_in     = req_value;
               res_sts_in = STS_OK;
               res_pos_in = '0;
               res_rem_in = '0;
               scan_in    = '0;
               pos_in     = CNT_W'(1);
               addr_in    = head_ff;
               state_in   = ST_RESP;
               case (cmd_type'(req_command))
                  CMD_APPEND: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        res_sts_in = STS_FULL;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_SEARCH, CMD_DEL_VALUE, CMD_DEL_BEFORE, CMD_DEL_AFTER: begin
                     if (count_ff == '0) begin
                        res_sts_in = STS_EMPTY;
                     end else begin
                        state_in = ST_FIND_RD;
                     end
                  end
                  CMD_DEL_FIRST: begin
                     if (count_ff == '0) begin
                        res_sts_in = STS_EMPTY;
                     end else begin
                        state_in = ST_UNL_RD;
                     end
                  end
                  CMD_DEL_LAST: begin
                     addr_in = tail_ff;
                     if (count_ff == '0) begin
                        res_sts_in = STS_EMPTY;
                     end else begin
                        state_in = ST_UNL_RD;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!in_use_ff[scan_ff]) begin
               state_in = ST_APP_NODE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_APP_NODE: begin
            val_we = 1'b1;
            nxt_we = 1'b1;
            prv_we = 1'b1;
            in_use_in[scan_ff] = 1'b1;
            if (count_ff == '0) begin
               head_in  = scan_ff;
               tail_in  = scan_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_RESP;
            end else begin
               nxt_wd   = head_ff;
               prv_wd   = tail_ff;
               state_in = ST_APP_LINK;
            end
         end
         ST_APP_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = tail_ff;
            prv_we   = 1'b1;
            prv_wa   = head_ff;
            tail_in  = scan_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_RESP;
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            if (val_rd_ff == key_ff) begin
               res_pos_in = pos_ff;
               state_in   = ST_RESP;
               case (cmd_ff)
                  CMD_DEL_VALUE: begin
                     state_in = ST_UNL_RD;
                  end
                  CMD_DEL_BEFORE: begin
                     if (addr_ff == head_ff) begin
                        res_sts_in = STS_NO_NEIGHBOR;
                     end else begin
                        addr_in  = prv_rd_ff;
                        state_in = ST_UNL_RD;
                     end
                  end
                  CMD_DEL_AFTER: begin
                     if (addr_ff == tail_ff) begin
                        res_sts_in = STS_NO_NEIGHBOR;
                     end else begin
                        addr_in  = nxt_rd_ff;
                        state_in = ST_UNL_RD;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end else if (pos_ff == count_ff) begin
               res_sts_in = STS_NOT_FOUND;
               state_in   = ST_RESP;
            end else begin
               pos_in   = pos_ff + CNT_W'(1);
               addr_in  = nxt_rd_ff;
               state_in = ST_FIND_RD;
            end
         end
         ST_UNL_RD: begin
            state_in = ST_UNL_DAT;
         end
         ST_UNL_DAT: begin
            res_rem_in         = val_rd_ff;
            in_use_in[addr_ff] = 1'b0;
            state_in           = ST_RESP;
            if (count_ff <= CNT_W'(1)) begin
               count_in = '0;
               head_in  = '0;
               tail_in  = '0;
            end else begin
               nxt_we   = 1'b1;
               nxt_wa   = prv_rd_ff;
               nxt_wd   = nxt_rd_ff;
               prv_we   = 1'b1;
               prv_wa   = nxt_rd_ff;
               prv_wd   = prv_rd_ff;
               count_in = count_ff - CNT_W'(1);
               if (addr_ff == head_ff) begin
                  head_in = nxt_rd_ff;
               end
               if (addr_ff == tail_ff) begin
                  tail_in = prv_rd_ff;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_sts_ff;
               rsp_position_in = LEN_W'(res_pos_ff);
               rsp_length_in   = LEN_W'(count_ff);
               rsp_removed_in  = res_rem_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_length        = rsp_length_ff;
   assign rsp_removed_value = rsp_removed_ff;

   `LLDM_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `LLDM_ASSERT_NOW(a_empty_links, clock, reset, count_ff == '0, head_ff == '0 && tail_ff == '0, "empty list with nonzero head or tail")
   `LLDM_ASSERT_NOW(a_single_node, clock, reset, count_ff == CNT_W'(1), head_ff == tail_ff, "single entry with head not tail")
   `LLDM_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall, "request taken but not busy")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import lldm_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int         WATCH_LIMIT = 20000;
   localparam int         LONG_HOLD = 400;

   typedef struct {
      logic [2:0]               status;
      logic [LEN_W-1:0]         position;
      logic [LEN_W-1:0]         length;
      logic signed [DATA_W-1:0] removed;
   } list_result_type;

   class list_scoreboard;
      logic signed [DATA_W-1:0] contents[$];
      list_result_type          pending[$];
      int                       errors;
      int                       checked;
      int                       full_hits;

      function int locate(logic signed [DATA_W-1:0] v);
         for (int i = 0; i < contents.size(); i++)
            if (contents[i] == v) return i;
         return -1;
      endfunction

      function void note(logic [2:0] cmd, logic signed [DATA_W-1:0] v);
         list_result_type r;
         int              idx;
         r.status   = STS_OK;
         r.position = '0;
         r.removed  = '0;
         if (cmd == CMD_APPEND) begin
            if (contents.size() >= CAPACITY) begin
               r.status = STS_FULL;
               full_hits++;
            end else begin
               contents.push_back(v);
            end
         end else if (cmd != CMD_UNUSED) begin
            if (contents.size() == 0) begin
               r.status = STS_EMPTY;
            end else if (cmd == CMD_DEL_FIRST) begin
               r.removed = contents.pop_front();
            end else if (cmd == CMD_DEL_LAST) begin
               r.removed = contents.pop_back();
            end else begin
               idx = locate(v);
               if (idx < 0) begin
                  r.status = STS_NOT_FOUND;
               end else begin
                  r.position = LEN_W'(idx + 1);
                  if (cmd == CMD_DEL_VALUE) begin
                     r.removed = contents[idx];
                     contents.delete(idx);
                  end else if (cmd == CMD_DEL_BEFORE) begin
                     if (idx == 0) r.status = STS_NO_NEIGHBOR;
                     else begin
                        r.removed = contents[idx-1];
                        contents.delete(idx-1);
                     end
                  end else if (cmd == CMD_DEL_AFTER) begin
                     if (idx == contents.size() - 1) r.status = STS_NO_NEIGHBOR;
                     else begin
                        r.removed = contents[idx+1];
                        contents.delete(idx+1);
                     end
                  end
               end
            end
         end
         r.length = LEN_W'(contents.size());
         pending.push_back(r);
      endfunction

      function void check(list_result_type act);
         list_result_type exp;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected transaction: status %0d pos %0d len %0d removed %0d",
                        act.status, act.position, act.length, act.removed);
            return;
         end
         exp = pending.pop_front();
         if (act.status !== exp.status || act.position !== exp.position ||
             act.length !== exp.length || act.removed !== exp.removed) begin
            errors++;
            if (errors <= 10)
               $display("mismatch %0d: exp st %0d pos %0d len %0d rem %0d, got st %0d pos %0d len %0d rem %0d",
                        checked, exp.status, exp.position, exp.length, exp.removed,
                        act.status, act.position, act.length, act.removed);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_command = CMD_APPEND;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [2:0]               rsp_status;
   logic [LEN_W-1:0]         rsp_position;
   logic [LEN_W-1:0]         rsp_length;
   logic signed [DATA_W-1:0] rsp_removed_value;

   list_scoreboard           sb = new();
   logic signed [DATA_W-1:0] value_pool[12];
   bit                       quiet = 1'b0;
   bit                       long_hold = 1'b0;
   bit                       start_hold = 1'b0;
   int                       stall_left = 0;
   int                       idle_cycles = 0;
   int                       sent = 0;

   always #10 clock = ~clock;

   linked_list_delete_manager_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_position      (rsp_position),
      .rsp_length        (rsp_length),
      .rsp_removed_value (rsp_removed_value)
   );

   always @(posedge clock) begin
      list_result_type act;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            act.status   = rsp_status;
            act.position = rsp_position;
            act.length   = rsp_length;
            act.removed  = rsp_removed_value;
            sb.check(act);
            stall_left = quiet ? 0 : $urandom_range(0, 3);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= long_hold || (stall_left > 0);
      end
   end

   initial begin
      wait (start_hold);
      long_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("watchdog expired with %0d transactions outstanding", sb.pending.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send(logic [2:0] cmd, logic signed [DATA_W-1:0] v);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= v;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note(cmd, v);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && sb.contents.size() != 0)
         return sb.contents[$urandom_range(0, sb.contents.size() - 1)];
      if (r < 80) return value_pool[$urandom_range(0, 11)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_cmd(int grow_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < grow_pct) return CMD_APPEND;
      if (r == 99) return CMD_UNUSED;
      case ($urandom_range(0, 5))
         0: return CMD_SEARCH;
         1: return CMD_DEL_FIRST;
         2: return CMD_DEL_LAST;
         3: return CMD_DEL_VALUE;
         4: return CMD_DEL_BEFORE;
         default: return CMD_DEL_AFTER;
      endcase
   endfunction

   initial begin
      int grow;
      int len;
      int phase;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (int i = 4; i < 12; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(CMD_SEARCH, 5);
      send(CMD_DEL_FIRST, 0);
      send(CMD_DEL_LAST, 0);
      send(CMD_DEL_VALUE, 5);
      send(CMD_DEL_BEFORE, 5);
      send(CMD_DEL_AFTER, 5);
      send(CMD_UNUSED, -1);
      send(CMD_APPEND, 32'sh8000_0000);
      send(CMD_DEL_BEFORE, 32'sh8000_0000);
      send(CMD_DEL_AFTER, 32'sh8000_0000);
      send(CMD_APPEND, 32'sh7fff_ffff);
      send(CMD_APPEND, 0);
      send(CMD_APPEND, -1);
      send(CMD_SEARCH, -1);
      send(CMD_SEARCH, -1);
      send(CMD_SEARCH, 12345);
      send(CMD_DEL_BEFORE, 32'sh8000_0000);
      send(CMD_DEL_AFTER, -1);
      send(CMD_DEL_AFTER, 32'sh8000_0000);
      send(CMD_DEL_BEFORE, -1);
      send(CMD_DEL_VALUE, 32'sh8000_0000);
      send(CMD_UNUSED, 7);
      send(CMD_DEL_FIRST, 0);
      send(CMD_DEL_LAST, 0);

      phase = 0;
      while (sent < 1900) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (phase == 3) begin
            while (sb.contents.size() < CAPACITY) send(CMD_APPEND, pick_value());
            repeat (6) send(CMD_APPEND, $urandom);
            repeat (4) send(pick_cmd(0), pick_value());
            grow = 20;
         end else begin
            grow = (phase % 3 == 0) ? 70 : (phase % 3 == 1) ? 25 : 45;
         end
         if (phase == 5) start_hold = 1'b1;
         len = $urandom_range(20, 80);
         repeat (len) send(pick_cmd(grow), pick_value());
         if (phase == 7) drain();
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      $display("%0d transactions sent over %0d phases, store full seen %0d times",
               sent, phase, sb.full_hits);
      $display("%0d responses checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/lldm_pkg.sv
rtl/linked_list_delete_manager_unit.sv
verif/tb.sv
